// ===== sv/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing under synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define QLM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define QLM_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define QLM_ASSERT(name, clk, rst_n, prop, msg)
`define QLM_ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// ===== sv/qlm_pkg.sv =====
// ============================================================================
// Queued lock manager package
// Command and status codes and the item type passed from front to back.
// ============================================================================
`default_nettype none

package qlm_pkg;

  localparam int unsigned NODE_W   = 8;
  localparam int unsigned LOCK_W   = 8;
  localparam int unsigned STATUS_W = 3;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_GRANTED    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_QUEUED     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FREED      = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_HANDED     = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_BAD_LOCK   = 3'd5;
  localparam logic [STATUS_W-1:0] STATUS_NOT_HOLDER = 3'd6;

  // One classified command as it waits between the front and the back.
  typedef struct packed {
    logic              cmd;
    logic [NODE_W-1:0] node;
    logic [LOCK_W-1:0] lock;
    logic              bad;
  } item_t;

endpackage

`default_nettype wire

// ===== sv/qlm_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with a registered read data output.
// ============================================================================
`default_nettype none

module qlm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== sv/qlm_front.sv =====
// ============================================================================
// Queued lock manager front
// Accepts commands, flags out-of-range lock indices and buffers them in a
// two-entry queue for the back end.
// ============================================================================
`default_nettype none

module qlm_front #(
  parameter int unsigned NUM_LOCKS = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       command_i,
  input  wire logic [qlm_pkg::NODE_W-1:0] requester_node_i,
  input  wire logic [qlm_pkg::LOCK_W-1:0] lock_index_i,
  output logic                            q_valid_o,
  output qlm_pkg::item_t                  q_item_o,
  input  wire logic                       q_pop_i
);

  qlm_pkg::item_t       slot_q [2];
  qlm_pkg::item_t       new_item;
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           count_q, count_d;
  logic                 push;

  // A lock index at or above the table size is flagged here once.
  always_comb begin
    new_item.cmd  = command_i;
    new_item.node = requester_node_i;
    new_item.lock = lock_index_i;
    new_item.bad  = ({1'b0, lock_index_i} >= (qlm_pkg::LOCK_W + 1)'(NUM_LOCKS));
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !q_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/qlm_back.sv =====
// ============================================================================
// Queued lock manager back end
// Reads one lock entry, updates it and its waiter ring, and registers the
// result for the output channel.
// ============================================================================
`default_nettype none

module qlm_back #(
  parameter int unsigned NUM_LOCKS   = 64,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  input  qlm_pkg::item_t                    q_item_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [qlm_pkg::STATUS_W-1:0]      status_o,
  output logic                              grant_valid_o,
  output logic [qlm_pkg::NODE_W-1:0]        grant_node_o,
  output logic [qlm_pkg::LOCK_W-1:0]        grant_lock_o
);

  localparam int unsigned LKW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int unsigned HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SD  = NUM_LOCKS * QUEUE_DEPTH;
  localparam int unsigned SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int unsigned PRW = SAW + 9;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_HAND = 2'd2;

  typedef struct packed {
    logic                       taken;
    logic [qlm_pkg::NODE_W-1:0] holder;
    logic [LW-1:0]              len;
    logic [HW-1:0]              head;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  logic [1:0]                   state_q, state_d;
  qlm_pkg::item_t               item_q;
  logic [NUM_LOCKS-1:0]         valid_q;
  logic [LKW-1:0]               lk;

  logic                         ent_rd_en, ent_wr_en;
  logic [EW-1:0]                ent_rd_data;
  entry_t                       ent, ent_new;

  logic                         slot_rd_en, slot_wr_en;
  logic [SAW-1:0]               slot_base, slot_wr_addr, slot_rd_addr;
  logic [PRW-1:0]               slot_prod;
  logic [qlm_pkg::NODE_W-1:0]   slot_rd_data;
  logic [LW:0]                  pos_sum;
  logic [HW-1:0]                pos;
  logic [HW:0]                  head_inc;
  logic [HW-1:0]                head_next;

  logic                         out_free, emit;
  logic [qlm_pkg::STATUS_W-1:0] res_status;
  logic                         res_gv;
  logic [qlm_pkg::NODE_W-1:0]   res_node;
  logic [qlm_pkg::LOCK_W-1:0]   res_lock;

  logic                         out_valid_q;
  logic [qlm_pkg::STATUS_W-1:0] status_q;
  logic                         gv_q;
  logic [qlm_pkg::NODE_W-1:0]   gnode_q;
  logic [qlm_pkg::LOCK_W-1:0]   glock_q;

  assign lk  = item_q.lock[LKW-1:0];
  // An entry never written since reset reads as a free lock with empty ring.
  assign ent = valid_q[lk] ? entry_t'(ent_rd_data) : '0;

  // Ring position of the tail and the head after a pop.
  always_comb begin
    pos_sum = (LW + 1)'(ent.head) + (LW + 1)'(ent.len);
    if (pos_sum >= (LW + 1)'(QUEUE_DEPTH)) begin
      pos_sum = pos_sum - (LW + 1)'(QUEUE_DEPTH);
    end
    pos      = pos_sum[HW-1:0];
    head_inc = (HW + 1)'(ent.head) + (HW + 1)'(1);
    if (head_inc == (HW + 1)'(QUEUE_DEPTH)) begin
      head_next = '0;
    end else begin
      head_next = head_inc[HW-1:0];
    end
  end

  assign slot_prod    = PRW'(lk) * PRW'(QUEUE_DEPTH);
  assign slot_base    = slot_prod[SAW-1:0];
  assign slot_wr_addr = slot_base + SAW'(pos);
  assign slot_rd_addr = slot_base + SAW'(ent.head);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    q_pop_o    = 1'b0;
    ent_rd_en  = 1'b0;
    ent_wr_en  = 1'b0;
    ent_new    = ent;
    slot_rd_en = 1'b0;
    slot_wr_en = 1'b0;
    emit       = 1'b0;
    res_status = qlm_pkg::STATUS_BAD_LOCK;
    res_gv     = 1'b0;
    res_node   = '0;
    res_lock   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          ent_rd_en = !q_item_i.bad;
          state_d   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (item_q.bad) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (item_q.cmd == qlm_pkg::CMD_REQUEST) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = ST_IDLE;
            if (!ent.taken) begin
              ent_wr_en      = 1'b1;
              ent_new.taken  = 1'b1;
              ent_new.holder = item_q.node;
              res_status     = qlm_pkg::STATUS_GRANTED;
              res_gv         = 1'b1;
              res_node       = item_q.node;
              res_lock       = item_q.lock;
            end else if (ent.len < LW'(QUEUE_DEPTH)) begin
              ent_wr_en   = 1'b1;
              slot_wr_en  = 1'b1;
              ent_new.len = ent.len + LW'(1);
              res_status  = qlm_pkg::STATUS_QUEUED;
            end else begin
              res_status = qlm_pkg::STATUS_FULL;
            end
          end
        end else if (!ent.taken || ent.holder != item_q.node) begin
          if (out_free) begin
            emit       = 1'b1;
            res_status = qlm_pkg::STATUS_NOT_HOLDER;
            state_d    = ST_IDLE;
          end
        end else if (ent.len != '0) begin
          // Fetch the oldest waiter from the slot memory; the handover finishes in ST_HAND.
          slot_rd_en = 1'b1;
          state_d    = ST_HAND;
        end else if (out_free) begin
          emit           = 1'b1;
          ent_wr_en      = 1'b1;
          ent_new.taken  = 1'b0;
          ent_new.holder = '0;
          res_status     = qlm_pkg::STATUS_FREED;
          state_d        = ST_IDLE;
        end
      end
      ST_HAND: begin
        if (out_free) begin
          emit           = 1'b1;
          ent_wr_en      = 1'b1;
          ent_new.holder = slot_rd_data;
          ent_new.head   = head_next;
          ent_new.len    = ent.len - LW'(1);
          res_status     = qlm_pkg::STATUS_HANDED;
          res_gv         = 1'b1;
          res_node       = slot_rd_data;
          res_lock       = item_q.lock;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  qlm_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_LOCKS)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ent_wr_en),
    .wr_addr_i (lk),
    .wr_data_i (ent_new),
    .rd_en_i   (ent_rd_en),
    .rd_addr_i (q_item_i.lock[LKW-1:0]),
    .rd_data_o (ent_rd_data)
  );

  qlm_ram #(
    .WIDTH (qlm_pkg::NODE_W),
    .DEPTH (SD)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (slot_wr_en),
    .wr_addr_i (slot_wr_addr),
    .wr_data_i (item_q.node),
    .rd_en_i   (slot_rd_en),
    .rd_addr_i (slot_rd_addr),
    .rd_data_o (slot_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ent_wr_en) begin
        valid_q[lk] <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    if (emit) begin
      status_q <= res_status;
      gv_q     <= res_gv;
      gnode_q  <= res_node;
      glock_q  <= res_lock;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign grant_valid_o = gv_q;
  assign grant_node_o  = gnode_q;
  assign grant_lock_o  = glock_q;

endmodule

`default_nettype wire

// ===== sv/queued_lock_manager_unit.sv =====
// ============================================================================
// Queued lock manager
// Central lock table with a FIFO waiter ring per lock.
// ============================================================================
// Usage: each transfer on the input channel (in_valid_i / in_stall_o) carries
// one command, a request or a release, from one node for one lock. Each
// command produces exactly one transfer on the output channel
// (out_valid_o / out_stall_i) with a status and, for a grant or a handover,
// the node and lock that the grant message must go to.
// Flow: a command waits in the two-entry input queue; the back end takes
// it in ST_IDLE while reading its lock entry, and registers the result from
// ST_EVAL, or from ST_HAND when a release hands the lock to a waiter, after
// the read of the waiter slot memory. A new command is taken only back in
// ST_IDLE, after the read and the write of the lock entry for the last one.
// Reset: every lock reads as free with an empty waiter ring at once, through
// a valid bit per lock entry; no clearing pass is run. Waiter slots are not
// cleared, since only slots written by a queued request are ever read.
// Stalls: the output register holds its result while out_stall_i is high;
// the two-entry input queue keeps accepting until it fills, and only then
// raises in_stall_o.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module queued_lock_manager_unit #(
  parameter int unsigned NUM_LOCKS   = 64,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         command_i,
  input  wire logic [qlm_pkg::NODE_W-1:0]   requester_node_i,
  input  wire logic [qlm_pkg::LOCK_W-1:0]   lock_index_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [qlm_pkg::STATUS_W-1:0]      status_o,
  output logic                              grant_valid_o,
  output logic [qlm_pkg::NODE_W-1:0]        grant_node_o,
  output logic [qlm_pkg::LOCK_W-1:0]        grant_lock_o
);

  // Classified commands waiting between the front and the back end.
  logic           q_valid;
  logic           q_pop;
  qlm_pkg::item_t q_item;

  // The front flags bad lock indices and buffers commands.
  qlm_front #(
    .NUM_LOCKS (NUM_LOCKS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .requester_node_i (requester_node_i),
    .lock_index_i     (lock_index_i),
    .q_valid_o        (q_valid),
    .q_item_o         (q_item),
    .q_pop_i          (q_pop)
  );

  // The back end performs the read-modify-write of the lock table and
  // registers the result.
  qlm_back #(
    .NUM_LOCKS   (NUM_LOCKS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .grant_valid_o (grant_valid_o),
    .grant_node_o  (grant_node_o),
    .grant_lock_o  (grant_lock_o)
  );

  // The back end never takes a command from an empty queue.
  `QLM_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && !q_valid, "pop from empty queue")

  // A grant accompanies exactly the granted and handed-over statuses.
  `QLM_ASSERT(a_grant_status, clk_i, rst_ni, out_valid_o |-> (grant_valid_o == ((status_o == qlm_pkg::STATUS_GRANTED) || (status_o == qlm_pkg::STATUS_HANDED))), "grant flag does not match status")

  // Without a grant the grant fields stay zero.
  `QLM_ASSERT(a_grant_zero, clk_i, rst_ni, (out_valid_o && !grant_valid_o) |-> ((grant_node_o == '0) && (grant_lock_o == '0)), "grant fields set without a grant")

  // A bad lock result never carries a grant.
  `QLM_ASSERT_NEVER(a_bad_grant, clk_i, rst_ni, out_valid_o && grant_valid_o && (status_o == qlm_pkg::STATUS_BAD_LOCK), "grant on a bad lock")

endmodule

`default_nettype wire

// ===== dv/tb_queued_lock_manager_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Queued lock manager testbench
// Sends lock requests and releases, with random gaps and output stalls, and
// checks each reply against a lock table kept inside the testbench.
// ============================================================================

module tb_queued_lock_manager_unit;

  localparam int unsigned NODE_W     = qlm_pkg::NODE_W;
  localparam int unsigned LOCK_W     = qlm_pkg::LOCK_W;
  localparam int unsigned STATUS_W   = qlm_pkg::STATUS_W;
  localparam int unsigned N_LOCKS    = 64;
  localparam int unsigned Q_DEPTH    = 16;
  localparam int          RANDOM_END = 900;   // the stimulus stops once at least this many items are sent
  localparam int          IDLE_LIMIT = 2000;  // cycles without any transfer
  localparam int          DRAIN_WAIT = 8;     // cycles after the last reply

  // One reply of the block, in port order.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                grant_valid;
    logic [NODE_W-1:0]   grant_node;
    logic [LOCK_W-1:0]   grant_lock;
  } lock_reply_t;

  // One row of the directed table. A row repeats its command count times,
  // with the node number stepping up by one each time. Where reply_fixed is
  // set, the reply is typed into the row; otherwise the lock table decides.
  typedef struct packed {
    logic              cmd;
    logic [NODE_W-1:0] node;
    logic [LOCK_W-1:0] lock;
    logic [4:0]        count;
    logic              reply_fixed;
    lock_reply_t       reply;
  } directed_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                command_i = qlm_pkg::CMD_REQUEST;
  logic [NODE_W-1:0]   requester_node_i = '0;
  logic [LOCK_W-1:0]   lock_index_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic                grant_valid_o;
  logic [NODE_W-1:0]   grant_node_o;
  logic [LOCK_W-1:0]   grant_lock_o;

  // The lock table as the testbench sees it: one busy flag, owner and waiter
  // ring per lock. The ring is indexed by head pointer plus waiter count.
  logic              lock_busy   [N_LOCKS];
  logic [NODE_W-1:0] lock_owner  [N_LOCKS];
  int                waiters     [N_LOCKS];
  int                ring_head   [N_LOCKS];
  logic [NODE_W-1:0] ring_slots  [N_LOCKS][Q_DEPTH];

  // Replies owed by the block, oldest first.
  lock_reply_t lock_replies_due[$];

  int  mismatch_count = 0;
  int  items_sent = 0;
  bit  no_gap_stretch = 1'b0;
  int  stall_run_left = 0;
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  int  idle_cycles = 0;

  // Lock 0 and the last lock cover every valid index bit; the two middle
  // locks keep some traffic away from the edges of the table.
  int hot_locks[4] = '{0, 21, 42, 63};

  directed_row_t directed_rows[12] = '{
    // A request to a free lock right after reset is granted at once.
    '{qlm_pkg::CMD_REQUEST, 8'd0, 8'd0, 5'd1, 1'b1,
      '{qlm_pkg::STATUS_GRANTED, 1'b1, 8'd0, 8'd0}},
    // The holder gives it back with no one waiting.
    '{qlm_pkg::CMD_RELEASE, 8'd0, 8'd0, 5'd1, 1'b1,
      '{qlm_pkg::STATUS_FREED, 1'b0, 8'd0, 8'd0}},
    // A release of a lock that nobody holds is refused.
    '{qlm_pkg::CMD_RELEASE, 8'd0, 8'd0, 5'd1, 1'b1,
      '{qlm_pkg::STATUS_NOT_HOLDER, 1'b0, 8'd0, 8'd0}},
    // Lock indices past the table, for both commands.
    '{qlm_pkg::CMD_REQUEST, 8'd255, 8'd64, 5'd1, 1'b1,
      '{qlm_pkg::STATUS_BAD_LOCK, 1'b0, 8'd0, 8'd0}},
    '{qlm_pkg::CMD_RELEASE, 8'd255, 8'd255, 5'd1, 1'b1,
      '{qlm_pkg::STATUS_BAD_LOCK, 1'b0, 8'd0, 8'd0}},
    // The last lock goes to the highest node.
    '{qlm_pkg::CMD_REQUEST, 8'd255, 8'd63, 5'd1, 1'b1,
      '{qlm_pkg::STATUS_GRANTED, 1'b1, 8'd255, 8'd63}},
    // Another node tries to release it.
    '{qlm_pkg::CMD_RELEASE, 8'd0, 8'd63, 5'd1, 1'b1,
      '{qlm_pkg::STATUS_NOT_HOLDER, 1'b0, 8'd0, 8'd0}},
    // The holder asks again and waits behind itself.
    '{qlm_pkg::CMD_REQUEST, 8'd255, 8'd63, 5'd1, 1'b0, '0},
    // Nodes 1 to 15 fill the rest of the waiter ring.
    '{qlm_pkg::CMD_REQUEST, 8'd1, 8'd63, 5'd15, 1'b0, '0},
    // With the ring full the next request is dropped.
    '{qlm_pkg::CMD_REQUEST, 8'd90, 8'd63, 5'd1, 1'b1,
      '{qlm_pkg::STATUS_FULL, 1'b0, 8'd0, 8'd0}},
    // The holder hands over to itself, then to node 1.
    '{qlm_pkg::CMD_RELEASE, 8'd255, 8'd63, 5'd1, 1'b0, '0},
    '{qlm_pkg::CMD_RELEASE, 8'd255, 8'd63, 5'd1, 1'b0, '0}
  };

  queued_lock_manager_unit #(
    .NUM_LOCKS   (N_LOCKS),
    .QUEUE_DEPTH (Q_DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .requester_node_i (requester_node_i),
    .lock_index_i     (lock_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .grant_valid_o    (grant_valid_o),
    .grant_node_o     (grant_node_o),
    .grant_lock_o     (grant_lock_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one command to the lock table and returns the reply it owes.
  function automatic lock_reply_t apply_lock_command(input logic cmd,
                                                     input logic [NODE_W-1:0] node,
                                                     input logic [LOCK_W-1:0] lock);
    lock_reply_t reply;
    int          idx;
    int          slot;
    reply = '0;
    idx = int'(lock);
    if (idx >= N_LOCKS) begin
      reply.status = qlm_pkg::STATUS_BAD_LOCK;
    end else if (cmd == qlm_pkg::CMD_REQUEST) begin
      if (!lock_busy[idx]) begin
        lock_busy[idx]    = 1'b1;
        lock_owner[idx]   = node;
        reply.status      = qlm_pkg::STATUS_GRANTED;
        reply.grant_valid = 1'b1;
        reply.grant_node  = node;
        reply.grant_lock  = lock;
      end else if (waiters[idx] < Q_DEPTH) begin
        // The holder itself may wait on its own lock.
        slot = (ring_head[idx] + waiters[idx]) % Q_DEPTH;
        ring_slots[idx][slot] = node;
        waiters[idx]++;
        reply.status = qlm_pkg::STATUS_QUEUED;
      end else begin
        reply.status = qlm_pkg::STATUS_FULL;
      end
    end else if (!lock_busy[idx] || lock_owner[idx] != node) begin
      reply.status = qlm_pkg::STATUS_NOT_HOLDER;
    end else if (waiters[idx] > 0) begin
      // The oldest waiter becomes the holder and gets the grant.
      lock_owner[idx]   = ring_slots[idx][ring_head[idx]];
      ring_head[idx]    = (ring_head[idx] + 1) % Q_DEPTH;
      waiters[idx]--;
      reply.status      = qlm_pkg::STATUS_HANDED;
      reply.grant_valid = 1'b1;
      reply.grant_node  = lock_owner[idx];
      reply.grant_lock  = lock;
    end else begin
      // The head pointer stays where it is when the lock is freed.
      lock_busy[idx]  = 1'b0;
      lock_owner[idx] = '0;
      reply.status    = qlm_pkg::STATUS_FREED;
    end
    return reply;
  endfunction

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gap_stretch || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t: mismatch on %s, got %0d, wanted %0d", $time, what, got, want);
  endtask

  // Offers one command and waits for its transfer. Valid stays high when the
  // next command follows with no gap, so it is never lowered and raised in
  // the same time step. The reply is worked out at the transfer, which keeps
  // the lock table in the block's order.
  task automatic send_lock_command(input logic cmd, input logic [NODE_W-1:0] node,
                                   input logic [LOCK_W-1:0] lock,
                                   input logic reply_fixed, input lock_reply_t fixed_reply);
    int          gap;
    lock_reply_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    requester_node_i <= node;
    lock_index_i     <= lock;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_lock_command(cmd, node, lock);
    lock_replies_due.push_back(reply_fixed ? fixed_reply : predicted);
    items_sent++;
  endtask

  // Stimulus: reset, the directed table, then random traffic until the
  // item count is reached.
  initial begin
    logic [LOCK_W-1:0] lock;
    logic [NODE_W-1:0] node;
    logic              cmd;
    int                r;

    for (int i = 0; i < N_LOCKS; i++) begin
      lock_busy[i]  = 1'b0;
      lock_owner[i] = '0;
      waiters[i]    = 0;
      ring_head[i]  = 0;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].count; k++) begin
        send_lock_command(directed_rows[i].cmd, directed_rows[i].node + NODE_W'(k),
                          directed_rows[i].lock, directed_rows[i].reply_fixed,
                          directed_rows[i].reply);
      end
    end

    // Random part. Most traffic hits a few hot locks so that waiter rings
    // grow, wrap and drain; most releases come from the real holder so that
    // handovers dominate. Foreign releases, stray lock indices and bursts
    // that overflow a ring make up the rest.
    while (items_sent < RANDOM_END) begin
      if (items_sent % 100 == 0) no_gap_stretch = ($urandom_range(3) == 0);
      r = $urandom_range(99);
      if (r < 6) begin
        lock = LOCK_W'($urandom_range(N_LOCKS, 255));
        cmd  = 1'($urandom_range(1));
        node = NODE_W'($urandom_range(255));
        send_lock_command(cmd, node, lock, 1'b0, '0);
      end else if (r < 8) begin
        // Enough requests on one lock to overflow its ring.
        lock = LOCK_W'(hot_locks[$urandom_range(3)]);
        repeat (Q_DEPTH + 2) begin
          send_lock_command(qlm_pkg::CMD_REQUEST, NODE_W'($urandom_range(255)), lock,
                            1'b0, '0);
        end
      end else begin
        if ($urandom_range(99) < 75) lock = LOCK_W'(hot_locks[$urandom_range(3)]);
        else lock = LOCK_W'($urandom_range(N_LOCKS - 1));
        r = $urandom_range(99);
        if (lock_busy[lock] && r < 45) begin
          cmd  = qlm_pkg::CMD_RELEASE;
          node = lock_owner[lock];
        end else if (r < 55) begin
          cmd  = qlm_pkg::CMD_RELEASE;
          node = NODE_W'($urandom_range(255));
        end else begin
          cmd  = qlm_pkg::CMD_REQUEST;
          node = ($urandom_range(1) != 0) ? NODE_W'($urandom_range(7))
                                           : NODE_W'($urandom_range(255));
        end
        send_lock_command(cmd, node, lock, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    // The watchdog ends the run if the block stops answering.
    while (lock_replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Reply side: stalls in runs of random length, with one long hold-off
  // partway through so that the block backs up into its input queue while
  // the sender keeps offering commands. Each reply transfer is checked
  // against the oldest owed reply.
  always @(posedge clk_i or negedge rst_ni) begin
    lock_reply_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (lock_replies_due.size() == 0) begin
          report_mismatch("reply with none owed, status", int'(status_o), -1);
        end else begin
          want = lock_replies_due.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", int'(status_o), int'(want.status));
          if (grant_valid_o !== want.grant_valid)
            report_mismatch("grant_valid", int'(grant_valid_o), int'(want.grant_valid));
          if (grant_node_o !== want.grant_node)
            report_mismatch("grant_node", int'(grant_node_o), int'(want.grant_node));
          if (grant_lock_o !== want.grant_lock)
            report_mismatch("grant_lock", int'(grant_lock_o), int'(want.grant_lock));
        end
      end

      if (!long_hold_done && items_sent >= 400) begin
        long_hold_done = 1'b1;
        hold_left      = 120;
      end

      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_run_left > 0) begin
        stall_run_left--;
      end else begin
        r_pick_run();
      end
    end
  end

  // Chooses the next run of the reply side: a stretch with no stall, a
  // short stall, or now and then a long one.
  task automatic r_pick_run();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      out_stall_i    <= 1'b0;
      stall_run_left = $urandom_range(4, 60) - 1;
    end else if (r < 90) begin
      out_stall_i    <= 1'b1;
      stall_run_left = $urandom_range(1, 3) - 1;
    end else begin
      out_stall_i    <= 1'b1;
      stall_run_left = $urandom_range(10, 30) - 1;
    end
  endtask

  // Watchdog: a long run of cycles with no transfer on either side means
  // the block has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

endmodule
